### src/lss_pkg.sv
// Shared constants for the lidar sector steering block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lss_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_BASE_SPEED   = 3'd0;
	localparam logic [2:0] REG_GAIN_DIVISOR = 3'd1;
	localparam logic [2:0] REG_WALL_SCORE   = 3'd2;
	localparam logic [2:0] REG_WALL_BALANCE = 3'd3;
	localparam logic [2:0] REG_WALL_TURN    = 3'd4;
	localparam logic [2:0] REG_NEAR_LIMIT   = 3'd5;
	localparam logic [2:0] REG_SECTOR_EDGE  = 3'd6;

	// Register reset values
	localparam logic [9:0]  RST_BASE_SPEED   = 10'd100;
	localparam logic [9:0]  RST_GAIN_DIVISOR = 10'd70;
	localparam logic [15:0] RST_WALL_SCORE   = 16'd700;
	localparam logic [9:0]  RST_WALL_BALANCE = 10'd7;
	localparam logic [9:0]  RST_WALL_TURN    = 10'd50;
	localparam logic [15:0] RST_NEAR_LIMIT   = 16'd1500;
	localparam logic [14:0] RST_SECTOR_EDGE  = 15'd12000;

	// Score: 10 points per metre of inverse distance, Q8
	localparam int          PTS_W    = 22;
	localparam logic [PTS_W-1:0] PTS_NUM  = 22'd2560000;
	localparam logic [PTS_W-1:0] PTS_ZERO = 22'd2560;

	// Angle window, hundredths of degree
	localparam logic signed [16:0] SWEEP_LO = -17'sd18000;
	localparam logic signed [16:0] SWEEP_HI = 17'sd18000;

	// Turn magnitude cap (2^40) and total saturation
	localparam int                TURN_W    = 41;
	localparam logic [TURN_W-1:0] TURN_CAP  = 41'h100_0000_0000;
	localparam logic [39:0]       TOTAL_MAX = 40'hFF_FFFF_FFFF;

	// Speed arithmetic width and saturation limits
	localparam int                   SPD_W   = 43;
	localparam logic signed [SPD_W-1:0] SPD_HI = 43'sd8388607;
	localparam logic signed [SPD_W-1:0] SPD_LO = -43'sd8388608;

endpackage

### src/lidar_sector_steering.sv
// Lidar sector steering: per-scan wheel speeds from rear-sector obstacle scores.
// Depends on lss_pkg and lss_div.
`timescale 1ns / 1ps

// Usage
//   Slave stream (s_*): one lidar sample per transaction. s_tdata holds angle_cdeg
//   [15:0] (signed) and distance_mm [31:16]; s_tuser is range_invalid; s_tlast marks
//   the final sample of a scan.
//   Master stream (m_*): one transaction per scan, issued after the sample carrying
//   s_tlast. Payload listed at the m_tdata port.
//   Config: cfg_wen/cfg_idx/cfg_wdata write one register per clock; write only idle.
// Timing
//   A scoring sample with nonzero distance runs a 1/distance divide on the shared
//   restoring divider before its score is added; other samples go straight to the
//   accumulate step. The last sample adds a second divide of the score
//   difference by gain_divisor on the same unit before m_tvalid is raised.
//   The divider (one quotient bit per clock) sets the rate.
//   s_tready is high only while the sequencer is idle.
// Reset and stall
//   arst_n clears the sequencer, both score sums and the output valid, and loads
//   register defaults. A result waits in the output register while m_tready is low;
//   new samples are still taken, and only a following scan end waits for the slot.

module lidar_sector_steering
	import lss_pkg::*;
#(
	parameter int ACC_WIDTH = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // angle_cdeg[15:0], distance_mm[31:16]
	input  logic         s_tuser,   // range_invalid
	input  logic         s_tlast,   // last_sample
	// master stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // left_speed_q8[23:0], right_speed_q8[47:24],
	                                // wall_seen[48], left_total_q8[88:49],
	                                // right_total_q8[128:89], zero pad [135:129]
	// configuration
	input  logic         cfg_wen,
	input  logic [2:0]   cfg_idx,
	input  logic [15:0]  cfg_wdata
);

	localparam int CW = (ACC_WIDTH > TURN_W) ? ACC_WIDTH : TURN_W;
	localparam int XW = (ACC_WIDTH > 40) ? ACC_WIDTH : 40;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_PTS,
		ST_ACCUM,
		ST_DIFF,
		ST_DIV_TURN,
		ST_TURN,
		ST_LOAD
	} state_t;

	state_t state_q;

	// configuration registers
	logic [9:0]  base_speed_q;
	logic [9:0]  gain_divisor_q;
	logic [15:0] wall_score_q;
	logic [9:0]  wall_balance_q;
	logic [9:0]  wall_turn_q;
	logic [15:0] near_limit_q;
	logic [14:0] sector_edge_q;

	// scan state
	logic [ACC_WIDTH-1:0] left_sum_q;
	logic [ACC_WIDTH-1:0] right_sum_q;
	logic                 out_valid_q;

	// per-item payload
	logic [PTS_W-1:0]  pts_q;
	logic              side_right_q;
	logic              last_q;
	logic [TURN_W-1:0] tu_q;
	logic [TURN_W-1:0] turn_mag_q;
	logic              turn_neg_q;
	logic              wall_q;
	logic [39:0]       ltot_q;
	logic [39:0]       rtot_q;
	logic [135:0]      out_data_q;

	// input decode
	logic signed [16:0] ang_s;
	logic signed [16:0] edge_s;
	logic [15:0]        dist_mm;
	logic               in_left;
	logic               in_right;
	logic               hit;
	logic               accept;

	assign ang_s    = {s_tdata[15], s_tdata[15:0]};
	assign edge_s   = $signed({2'b00, sector_edge_q});
	assign dist_mm  = s_tdata[31:16];
	assign in_left  = (ang_s >= SWEEP_LO) && (ang_s < -edge_s);
	assign in_right = (ang_s >= edge_s) && (ang_s < SWEEP_HI);
	assign hit      = !s_tuser && (dist_mm < near_limit_q) && (in_left || in_right);
	assign accept   = s_tvalid && s_tready;

	// shared divider
	logic                 div_start;
	logic [ACC_WIDTH-1:0] div_dividend;
	logic [15:0]          div_divisor;
	logic                 div_busy;
	logic                 div_done;
	logic [ACC_WIDTH-1:0] div_quo;
	logic [ACC_WIDTH-1:0] sum_diff;

	assign sum_diff = (left_sum_q > right_sum_q) ? (left_sum_q - right_sum_q)
	                                             : (right_sum_q - left_sum_q);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = ACC_WIDTH'(PTS_NUM);
		div_divisor  = dist_mm;
		if (state_q == ST_IDLE) begin
			div_start = accept && hit && (dist_mm != 16'd0);
		end else if (state_q == ST_DIFF) begin
			div_start    = 1'b1;
			div_dividend = sum_diff;
			div_divisor  = (gain_divisor_q == 10'd0) ? 16'd1 : {6'd0, gain_divisor_q};
		end
	end

	lss_div #(
		.DW (ACC_WIDTH),
		.VW (16)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// saturating accumulate of the pending score
	logic [ACC_WIDTH-1:0] acc_in;
	logic [ACC_WIDTH:0]   acc_sum;
	logic [ACC_WIDTH-1:0] acc_sat;

	assign acc_in  = side_right_q ? right_sum_q : left_sum_q;
	assign acc_sum = {1'b0, acc_in} + (ACC_WIDTH + 1)'(pts_q);
	assign acc_sat = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];

	// turn magnitude capped at 2^40
	logic [CW-1:0]     quo_ext;
	logic [TURN_W-1:0] tu_capped;

	assign quo_ext   = CW'(div_quo);
	assign tu_capped = (quo_ext > CW'(TURN_CAP)) ? TURN_CAP : quo_ext[TURN_W-1:0];

	// wall rule and totals
	logic [ACC_WIDTH-1:0] wall_thr;
	logic                 wall_hit;
	logic [XW-1:0]        lsum_ext;
	logic [XW-1:0]        rsum_ext;

	assign wall_thr = ACC_WIDTH'({wall_score_q, 8'd0});
	assign wall_hit = (tu_q < TURN_W'({wall_balance_q, 8'd0}))
	                  && (left_sum_q >= wall_thr) && (right_sum_q >= wall_thr);
	assign lsum_ext = XW'(left_sum_q);
	assign rsum_ext = XW'(right_sum_q);

	// wheel speeds
	logic signed [SPD_W-1:0] turn_s;
	logic signed [SPD_W-1:0] base_s;
	logic signed [SPD_W-1:0] lspd_raw;
	logic signed [SPD_W-1:0] rspd_raw;
	logic [23:0]             lspd;
	logic [23:0]             rspd;
	logic                    out_free;
	logic                    out_load;

	assign turn_s   = turn_neg_q ? -$signed({2'b00, turn_mag_q}) : $signed({2'b00, turn_mag_q});
	assign base_s   = $signed({25'd0, base_speed_q, 8'd0});
	assign lspd_raw = base_s + turn_s;
	assign rspd_raw = turn_s - base_s;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_LOAD) && out_free;

	always_comb begin
		priority if (lspd_raw > SPD_HI) lspd = SPD_HI[23:0];
		else if (lspd_raw < SPD_LO)     lspd = SPD_LO[23:0];
		else                            lspd = lspd_raw[23:0];
		priority if (rspd_raw > SPD_HI) rspd = SPD_HI[23:0];
		else if (rspd_raw < SPD_LO)     rspd = SPD_LO[23:0];
		else                            rspd = rspd_raw[23:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_speed_q   <= RST_BASE_SPEED;
			gain_divisor_q <= RST_GAIN_DIVISOR;
			wall_score_q   <= RST_WALL_SCORE;
			wall_balance_q <= RST_WALL_BALANCE;
			wall_turn_q    <= RST_WALL_TURN;
			near_limit_q   <= RST_NEAR_LIMIT;
			sector_edge_q  <= RST_SECTOR_EDGE;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_BASE_SPEED:   base_speed_q   <= cfg_wdata[9:0];
				REG_GAIN_DIVISOR: gain_divisor_q <= cfg_wdata[9:0];
				REG_WALL_SCORE:   wall_score_q   <= cfg_wdata;
				REG_WALL_BALANCE: wall_balance_q <= cfg_wdata[9:0];
				REG_WALL_TURN:    wall_turn_q    <= cfg_wdata[9:0];
				REG_NEAR_LIMIT:   near_limit_q   <= cfg_wdata;
				REG_SECTOR_EDGE:  sector_edge_q  <= cfg_wdata[14:0];
				default: ;  // unused index, dropped
			endcase
		end
	end

	// sequencer, score sums and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_sum_q  <= '0;
			right_sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result takes the slot; otherwise the slot drains on m_tready
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= div_start ? ST_DIV_PTS : ST_ACCUM;
				end
				ST_DIV_PTS: begin
					if (div_done) state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					if (side_right_q) right_sum_q <= acc_sat;
					else              left_sum_q  <= acc_sat;
					state_q <= last_q ? ST_DIFF : ST_IDLE;
				end
				ST_DIFF: begin
					state_q <= ST_DIV_TURN;
				end
				ST_DIV_TURN: begin
					if (div_done) state_q <= ST_TURN;
				end
				ST_TURN: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						left_sum_q  <= '0;
						right_sum_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			side_right_q <= in_right;
			last_q       <= s_tlast;
			pts_q        <= hit ? PTS_ZERO : '0;
		end
		if (state_q == ST_DIV_PTS && div_done) pts_q <= div_quo[PTS_W-1:0];
		if (state_q == ST_DIV_TURN && div_done) tu_q <= tu_capped;
		if (state_q == ST_TURN) begin
			wall_q     <= wall_hit;
			turn_mag_q <= wall_hit ? TURN_W'({wall_turn_q, 8'd0}) : tu_q;
			turn_neg_q <= left_sum_q <= right_sum_q;
			ltot_q     <= (lsum_ext > XW'(TOTAL_MAX)) ? TOTAL_MAX : lsum_ext[39:0];
			rtot_q     <= (rsum_ext > XW'(TOTAL_MAX)) ? TOTAL_MAX : rsum_ext[39:0];
		end
		if (out_load) begin
			out_data_q <= {7'd0, rtot_q, ltot_q, wall_q, rspd, lspd};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("sample accepted while divider busy");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_PTS || state_q == ST_DIV_TURN))
		else $error("divider finished outside a wait state");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && out_free) |=> (left_sum_q == '0 && right_sum_q == '0))
		else $error("scan sums not cleared after result");

	a_wall_turn: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_TURN) && wall_q |-> turn_mag_q == TURN_W'({wall_turn_q, 8'd0}))
		else $error("wall rule did not apply wall turn");

endmodule

### src/lss_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; instanced by lidar_sector_steering.
`timescale 1ns / 1ps

module lss_div #(
	parameter int DW = 40,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [VW:0]      shifted;
	logic [VW:0]      diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
